### design/ifde_pkg.sv
// ----------------------------------------------------------------------------
// ifde_pkg
// Shared constants, codes and types for the implicit field density evaluator.
// ----------------------------------------------------------------------------
package ifde_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int SLOT_BITS   = $clog2(MAX_POINTS);
  localparam int COUNT_BITS  = SLOT_BITS + 1;
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 12;
  localparam int DENS_BITS   = 21;
  localparam int POT_BITS    = 17;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [DENS_BITS-1:0] DENS_MAX  = 21'd1048576;
  localparam logic [DENS_BITS-1:0] EMPTY_MIN = 21'd1048576;  // 16.0 in Q5.16

  // input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COMBINE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT   = 3'd3;

  // kernel codes
  localparam logic [1:0] KER_MURAKAMI  = 2'd0;
  localparam logic [1:0] KER_NISHIMURA = 2'd1;

  // combine codes
  localparam logic [1:0] CMB_SUM = 2'd0;
  localparam logic [1:0] CMB_MAX = 2'd1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DENS_BITS-1:0]  dens_t;

endpackage

### design/implicit_field_density_evaluator.sv
// ----------------------------------------------------------------------------
// implicit_field_density_evaluator
// Metaball field density at a sample point over a small control point table.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_ready  | kind, slot, coord_x, coord_y
//  out_    | output    | out_valid / out_ready| density (Q5.16)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write transaction is absorbed at its accepting edge, with no result.
// An evaluate transaction squares the radius, then for each point squares
// the distances, checks the range, runs the divider, applies the kernel
// (Murakami, Nishimura near or far with a square root, or Wyvill) and
// accumulates; out of range points skip the divider and the kernel.
// The 32 step restoring divider computes d2 * 2^32 / R^2.
// Reset (synchronous, rst_n low) loads the register defaults; the point table
// is not cleared. in_ready is low during reset and from acceptance of an
// evaluate transaction until the result is taken.
//
module implicit_field_density_evaluator
  import ifde_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [SLOT_BITS-1:0]     in_slot,
  input  coord_t                   in_coord_x,
  input  coord_t                   in_coord_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dens_t                    out_density,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_R2   = 4'd1;
  localparam logic [3:0] ST_DX   = 4'd2;
  localparam logic [3:0] ST_DY   = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_KER  = 4'd6;
  localparam logic [3:0] ST_SQ   = 4'd7;
  localparam logic [3:0] ST_NF   = 4'd8;
  localparam logic [3:0] ST_W2   = 4'd9;
  localparam logic [3:0] ST_W3   = 4'd10;
  localparam logic [3:0] ST_W4   = 4'd11;
  localparam logic [3:0] ST_ACC  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  // ceil(2^23 / 9): exact floor(n/9) for n < 2^20
  localparam logic [19:0] RECIP9 = 20'd932068;

  logic [3:0]             state_r;
  logic [1:0]             kernel_r;
  logic [1:0]             mode_r;
  logic [RADIUS_BITS-1:0] radius_r;
  logic [COUNT_BITS-1:0]  pcount_r;

  coord_t                 tab_x_r [MAX_POINTS];
  coord_t                 tab_y_r [MAX_POINTS];
  coord_t                 sx_r, sy_r;
  logic [COUNT_BITS-1:0]  n_r, idx_r;
  logic [23:0]            r2_r;
  logic [24:0]            d2_r;
  logic [23:0]            rem_r;
  logic [31:0]            q_r;
  logic [4:0]             cnt_r;
  logic [31:0]            sq_v_r, sq_res_r, sq_bit_r;
  logic [31:0]            v2_r;
  logic [47:0]            v3_r;
  logic signed [24:0]     nwy_r;
  logic [POT_BITS-1:0]    p_r;
  dens_t                  acc_r;

  // distance to the current table point
  coord_t      cur_x, cur_y, dx, dy;
  logic [15:0] v;
  logic [16:0] t, u, w;

  assign cur_x = tab_x_r[idx_r[SLOT_BITS-1:0]];
  assign cur_y = tab_y_r[idx_r[SLOT_BITS-1:0]];
  assign dx    = (sx_r >= cur_x) ? sx_r - cur_x : cur_x - sx_r;
  assign dy    = (sy_r >= cur_y) ? sy_r - cur_y : cur_y - sy_r;
  assign v     = q_r[31:16];                  // u^2 in Q0.16
  assign t     = 17'd65536 - {1'b0, v};
  assign u     = sq_res_r[16:0];              // u in Q0.16
  assign w     = (u >= 17'd65536) ? 17'd0 : 17'd65536 - u;

  // shared multiplier
  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_R2: begin
        mul_a = 32'(radius_r);
        mul_b = 20'(radius_r);
      end
      ST_DX: begin
        mul_a = 32'(dx);
        mul_b = 20'(dx);
      end
      ST_DY: begin
        mul_a = 32'(dy);
        mul_b = 20'(dy);
      end
      ST_KER: begin
        if (kernel_r == KER_MURAKAMI) begin
          mul_a = 32'(t);
          mul_b = 20'(t);
        end else begin
          mul_a = 32'(v);
          mul_b = 20'(v);
        end
      end
      ST_NF: begin
        mul_a = 32'(w);
        mul_b = 20'(w);
      end
      ST_W2: begin
        mul_a = v2_r;
        mul_b = 20'(v);
      end
      ST_W4: begin
        mul_a = 32'(nwy_r[19:0]);
        mul_b = RECIP9;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 52'(mul_a) * 52'(mul_b);

  // restoring divider step
  logic [24:0] rem_sh;
  logic        div_ge;
  logic [24:0] rem_sub;
  assign rem_sh  = {rem_r, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, r2_r};
  assign rem_sub = div_ge ? rem_sh - {1'b0, r2_r} : rem_sh;

  // square root step
  logic [32:0] sq_sum;
  logic        sq_take;
  assign sq_sum  = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign sq_take = {1'b0, sq_v_r} >= sq_sum;

  // Nishimura near region: 1 - 3u^2
  logic        near;
  logic [17:0] three_v;
  logic [16:0] near_p;
  assign near    = (29'(d2_r) * 29'd9) < 29'(r2_r);
  assign three_v = 18'(v) * 18'd3;
  assign near_p  = (three_v >= 18'd65536) ? 17'd0 : 17'(18'd65536 - three_v);

  // Nishimura far region: 1.5 w^2
  logic [34:0] far3;
  assign far3 = 35'(prod[33:0]) * 35'd3;

  // Wyvill numerator scaled by 2^-32
  logic signed [55:0] wx;
  logic signed [24:0] wbase, wn;
  assign wx    = $signed(56'(53'({v2_r, 16'b0}) * 53'd17)) - $signed(56'({v3_r, 2'b0}));
  assign wbase = 25'sd589824 - $signed(25'(24'(v) * 24'd22));
  assign wn    = wbase + 25'(wx[55:32]);

  // combine
  logic [21:0] sum_ext;
  dens_t       acc_nxt;
  dens_t       p_ext;
  assign p_ext   = 21'(p_r);
  assign sum_ext = 22'(acc_r) + 22'(p_ext);

  always_comb begin
    unique case (mode_r)
      CMB_SUM: acc_nxt = (sum_ext > 22'(DENS_MAX)) ? DENS_MAX : sum_ext[DENS_BITS-1:0];
      CMB_MAX: acc_nxt = (p_ext > acc_r) ? p_ext : acc_r;
      default: acc_nxt = (p_ext < acc_r) ? p_ext : acc_r;
    endcase
  end

  logic [COUNT_BITS-1:0] idx_inc;
  assign idx_inc = idx_r + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KER_MURAKAMI;
      mode_r   <= CMB_SUM;
      radius_r <= 12'd100;
      pcount_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KERNEL:  kernel_r <= cfg_data[1:0];
        REG_COMBINE: mode_r   <= cfg_data[1:0];
        REG_RADIUS:  radius_r <= cfg_data[RADIUS_BITS-1:0];
        REG_COUNT:   pcount_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // point table, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_kind == KIND_WRITE) begin
      tab_x_r[in_slot] <= in_coord_x;
      tab_y_r[in_slot] <= in_coord_y;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_kind == KIND_EVAL) begin
            sx_r    <= in_coord_x;
            sy_r    <= in_coord_y;
            n_r     <= (pcount_r > COUNT_BITS'(MAX_POINTS)) ? COUNT_BITS'(MAX_POINTS)
                                                             : pcount_r;
            idx_r   <= '0;
            acc_r   <= (mode_r == CMB_SUM || mode_r == CMB_MAX) ? '0 : EMPTY_MIN;
            state_r <= ST_R2;
          end
        end
        ST_R2: begin
          r2_r    <= prod[23:0];
          state_r <= (n_r == '0) ? ST_OUT : ST_DX;
        end
        ST_DX: begin
          d2_r    <= 25'(prod[23:0]);
          state_r <= ST_DY;
        end
        ST_DY: begin
          d2_r    <= d2_r + 25'(prod[23:0]);
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (radius_r == '0 || d2_r >= 25'(r2_r)) begin
            p_r     <= '0;
            state_r <= ST_ACC;
          end else begin
            rem_r   <= d2_r[23:0];
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_sub[23:0];
          q_r   <= {q_r[30:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) state_r <= ST_KER;
        end
        ST_KER: begin
          unique case (kernel_r)
            KER_MURAKAMI: begin
              p_r     <= prod[32:16];
              state_r <= ST_ACC;
            end
            KER_NISHIMURA: begin
              if (near) begin
                p_r     <= near_p;
                state_r <= ST_ACC;
              end else begin
                sq_v_r   <= q_r;
                sq_res_r <= '0;
                sq_bit_r <= 32'h4000_0000;
                cnt_r    <= '0;
                state_r  <= ST_SQ;
              end
            end
            default: begin
              v2_r    <= prod[31:0];
              state_r <= ST_W2;
            end
          endcase
        end
        ST_SQ: begin
          if (sq_take) begin
            sq_v_r   <= sq_v_r - sq_sum[31:0];
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == 5'd15) state_r <= ST_NF;
        end
        ST_NF: begin
          p_r     <= far3[33:17];
          state_r <= ST_ACC;
        end
        ST_W2: begin
          v3_r    <= prod[47:0];
          state_r <= ST_W3;
        end
        ST_W3: begin
          nwy_r   <= wn;
          state_r <= ST_W4;
        end
        ST_W4: begin
          if (nwy_r <= 25'sd0)                  p_r <= '0;
          else if (prod[39:23] > 17'd65536)     p_r <= 17'd65536;
          else                                  p_r <= prod[39:23];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r   <= acc_nxt;
          idx_r   <= idx_inc;
          state_r <= (idx_inc == n_r) ? ST_OUT : ST_DX;
        end
        ST_OUT: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = rst_n && (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_OUT);
  assign out_density = acc_r;
  assign cfg_ready   = rst_n;

endmodule

### design/ifde_checker.sv
// ----------------------------------------------------------------------------
// ifde_checker
// Port level checks for the implicit field density evaluator.
// ----------------------------------------------------------------------------
module ifde_checker
  import ifde_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  in_kind,
  input logic  out_valid,
  input logic  out_ready,
  input dens_t out_density
);

  // one transaction at a time: no new input while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_density))
    else $error("result dropped or changed while stalled");

  a_dens_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_density <= DENS_MAX)
    else $error("density beyond saturation");

  // a write transaction produces no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_WRITE |=> !out_valid)
    else $error("write produced a result");

endmodule

bind implicit_field_density_evaluator ifde_checker u_ifde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_kind     (in_kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_density (out_density)
);
